// ===== rtl/pclvs_pkg.sv =====
// ----------------------------------------------------------------------------
// pclvs_pkg: shared types and constants of the PSU voltage sequencer
// Transfer payloads, configuration layout, power mode codes and helpers.
// ----------------------------------------------------------------------------
package pclvs_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VOLTAGE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOLTAGE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOLTAGE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_BAND    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_UP         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DOWN       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_SECONDS  = 3'd7;

    // Voltage window for a stable reading, and the seconds to ms factor.
    localparam logic [16:0] STABLE_WINDOW = 17'd100;
    localparam logic [9:0]  MS_PER_SECOND = 10'd1000;

    // Power state codes as seen on the result transfer.
    localparam logic [1:0] PS_OFF     = 2'd0;
    localparam logic [1:0] PS_INITIAL = 2'd1;
    localparam logic [1:0] PS_FULL    = 2'd2;

    typedef enum logic [2:0] {
        MODE_OFF     = 3'b001,
        MODE_INITIAL = 3'b010,
        MODE_FULL    = 3'b100
    } t_mode;

    typedef struct packed {
        logic        req_type;
        logic [31:0] now_ms;
        logic        power_on;
        logic [15:0] measured_voltage;
        logic [15:0] measured_current;
        logic        last_report;
    } t_in_item;

    typedef struct packed {
        logic [15:0] set_voltage;
        logic [1:0]  power_state;
        logic [31:0] state_elapsed_ms;
    } t_out_item;

    typedef struct packed {
        logic [15:0] initial_voltage;
        logic [15:0] max_voltage;
        logic [15:0] min_voltage;
        logic [15:0] current_limit;
        logic [15:0] current_band;
        logic [15:0] step_up;
        logic [15:0] step_down;
        logic [31:0] settle_ms;
    } t_cfg;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] mode_entered_ms;
        logic [31:0] stable_since_ms;
        logic [15:0] setpoint;
        logic        seen_over_high;
        logic        seen_over_low;
        logic        seen_unstable;
    } t_state;

    function automatic logic [1:0] mode_code(input t_mode mode);
        logic [1:0] code;
        unique case (mode)
            MODE_OFF:     code = PS_OFF;
            MODE_INITIAL: code = PS_INITIAL;
            MODE_FULL:    code = PS_FULL;
            default:      code = PS_OFF;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/psu_current_limit_voltage_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// psu_current_limit_voltage_sequencer_unit: PSU voltage sequencer
// A round's result is loaded into the output register at the transfer of
// its last report or step item.
// Throughput: one input transfer per cycle unless a held result is stalled;
// the round state and setpoint registers update at each transfer.
// Reset (synchronous, active low): initial power mode, zero setpoint, time
// marks and flags cleared, all configuration registers zero.
// ----------------------------------------------------------------------------
module psu_current_limit_voltage_sequencer_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    // Configuration write port.
    input  logic                                 i_cfg_we,
    input  logic [pclvs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pclvs_pkg::CFG_DATA_W-1:0]     i_cfg_data,

    // Report and step items.
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  pclvs_pkg::t_in_item                  i_in_item,

    // Round results.
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output pclvs_pkg::t_out_item                 o_out_item
);

    // Configuration registers. The settle time is kept in milliseconds so
    // the round logic needs no multiplier; the product is formed at the write.
    // The user must write only while idle; the block does not enforce it.
    pclvs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pclvs_pkg::CFG_INITIAL_VOLTAGE: r_cfg.initial_voltage <= i_cfg_data[15:0];
                pclvs_pkg::CFG_MAX_VOLTAGE:     r_cfg.max_voltage     <= i_cfg_data[15:0];
                pclvs_pkg::CFG_MIN_VOLTAGE:     r_cfg.min_voltage     <= i_cfg_data[15:0];
                pclvs_pkg::CFG_CURRENT_LIMIT:   r_cfg.current_limit   <= i_cfg_data[15:0];
                pclvs_pkg::CFG_CURRENT_BAND:    r_cfg.current_band    <= i_cfg_data[15:0];
                pclvs_pkg::CFG_STEP_UP:         r_cfg.step_up         <= i_cfg_data[15:0];
                pclvs_pkg::CFG_STEP_DOWN:       r_cfg.step_down       <= i_cfg_data[15:0];
                pclvs_pkg::CFG_SETTLE_SECONDS:  r_cfg.settle_ms       <=
                    32'(i_cfg_data) * 32'(pclvs_pkg::MS_PER_SECOND);
                default: ;
            endcase
        end
    end

    // The output register is the only buffer. A new transfer is taken
    // whenever that register is empty or is being drained in this cycle,
    // so a held result does not block input once the consumer takes it.
    logic r_out_valid;
    pclvs_pkg::t_out_item r_out_item;
    logic in_xfer;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_xfer    = i_in_valid & ~o_in_stall;

    // Round state: power mode, time marks, setpoint and gathered flags.
    pclvs_pkg::t_state r_state;
    pclvs_pkg::t_state n_state;
    pclvs_pkg::t_out_item n_result;
    logic emit;

    pclvs_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (i_in_item),
        .o_state  (n_state),
        .o_emit   (emit),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode            <= pclvs_pkg::MODE_INITIAL;
            r_state.mode_entered_ms <= '0;
            r_state.stable_since_ms <= '0;
            r_state.setpoint        <= '0;
            r_state.seen_over_high  <= 1'b0;
            r_state.seen_over_low   <= 1'b0;
            r_state.seen_unstable   <= 1'b0;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    // Result register. Only the last report of a round or a step item
    // loads a result; other reports just update the flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && emit) begin
            r_out_item <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/pclvs_step.sv =====
// ----------------------------------------------------------------------------
// pclvs_step: one report or step of the sequencer
// Gathers the round flags and, at the end of a round, moves the power mode
// and computes the new setpoint and the result transfer.
// ----------------------------------------------------------------------------
module pclvs_step (
    input  pclvs_pkg::t_cfg     i_cfg,
    input  pclvs_pkg::t_state   i_state,
    input  pclvs_pkg::t_in_item i_item,
    output pclvs_pkg::t_state   o_state,
    output logic                o_emit,
    output pclvs_pkg::t_out_item o_result
);

    logic [15:0] lo_limit;
    logic [15:0] hi_limit;
    logic [16:0] volt_diff;
    logic        unstable_now;
    logic        f_high;
    logic        f_low;
    logic        f_unstable;
    logic [31:0] stable_since;
    logic [31:0] settled_ms;
    pclvs_pkg::t_mode next_mode;
    logic [31:0] entered_ms;
    logic [16:0] up_sum;
    logic [15:0] full_v;
    logic [15:0] new_sp;

    always_comb begin
        lo_limit = i_cfg.current_limit - i_cfg.current_band;
        hi_limit = i_cfg.current_limit + i_cfg.current_band;

        if (i_item.measured_voltage > i_state.setpoint) begin
            volt_diff = {1'b0, i_item.measured_voltage} - {1'b0, i_state.setpoint};
        end else begin
            volt_diff = {1'b0, i_state.setpoint} - {1'b0, i_item.measured_voltage};
        end
        unstable_now = volt_diff > pclvs_pkg::STABLE_WINDOW;

        // A step item drops whatever a partial round had gathered.
        if (i_item.req_type) begin
            f_high     = 1'b0;
            f_low      = 1'b0;
            f_unstable = 1'b0;
        end else begin
            f_high     = i_state.seen_over_high | (i_item.measured_current > hi_limit);
            f_low      = i_state.seen_over_low | (i_item.measured_current > lo_limit);
            f_unstable = i_state.seen_unstable | unstable_now;
        end

        o_emit = i_item.req_type | i_item.last_report;

        // Power mode transition.
        stable_since = i_state.stable_since_ms;
        next_mode    = i_state.mode;
        if (!i_item.power_on) begin
            next_mode = pclvs_pkg::MODE_OFF;
        end else if (i_state.mode == pclvs_pkg::MODE_OFF) begin
            next_mode = pclvs_pkg::MODE_INITIAL;
        end else if (i_state.mode == pclvs_pkg::MODE_INITIAL && !i_item.req_type) begin
            if (f_unstable) begin
                stable_since = i_item.now_ms;
            end
            settled_ms = i_item.now_ms - stable_since;
            if (!f_unstable && settled_ms >= i_cfg.settle_ms) begin
                next_mode = pclvs_pkg::MODE_FULL;
            end
        end
        settled_ms = i_item.now_ms - stable_since;
        entered_ms = (next_mode != i_state.mode) ? i_item.now_ms : i_state.mode_entered_ms;

        // Full power setpoint from the current band.
        up_sum = {1'b0, i_state.setpoint} + {1'b0, i_cfg.step_up};
        if (f_high) begin
            full_v = (i_cfg.step_down > i_state.setpoint) ? 16'd0
                                                         : i_state.setpoint - i_cfg.step_down;
        end else if (f_low) begin
            full_v = i_state.setpoint;
        end else if (up_sum < {1'b0, i_cfg.max_voltage}) begin
            full_v = up_sum[15:0];
        end else begin
            full_v = i_state.setpoint;
        end
        if (full_v != 16'd0) begin
            if (full_v > i_cfg.max_voltage) begin
                full_v = i_cfg.max_voltage;
            end
            if (full_v < i_cfg.min_voltage) begin
                full_v = i_cfg.min_voltage;
            end
        end

        unique case (next_mode)
            pclvs_pkg::MODE_INITIAL: new_sp = i_cfg.initial_voltage;
            pclvs_pkg::MODE_FULL:    new_sp = full_v;
            default:                 new_sp = 16'd0;
        endcase

        // Next state: a report inside a round only keeps its flags.
        o_state = i_state;
        if (o_emit) begin
            o_state.mode            = next_mode;
            o_state.mode_entered_ms = entered_ms;
            o_state.stable_since_ms = stable_since;
            o_state.setpoint        = new_sp;
            o_state.seen_over_high  = 1'b0;
            o_state.seen_over_low   = 1'b0;
            o_state.seen_unstable   = 1'b0;
        end else begin
            o_state.seen_over_high  = f_high;
            o_state.seen_over_low   = f_low;
            o_state.seen_unstable   = f_unstable;
        end

        o_result.set_voltage      = new_sp;
        o_result.power_state      = pclvs_pkg::mode_code(next_mode);
        o_result.state_elapsed_ms = i_item.now_ms - entered_ms;
    end

endmodule

// ===== tb/psu_current_limit_voltage_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_current_limit_voltage_sequencer_unit_tb: self-checking bench
// Drives rectifier reports and step items into the PSU voltage sequencer. It
// predicts each round's setpoint, power state and time in state, and compares
// every result transfer with the oldest prediction. Configuration changes
// between phases, while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module psu_current_limit_voltage_sequencer_unit_tb;

    import pclvs_pkg::*;

    // Predicts the sequencer round by round and checks the result transfers.
    class setpoint_scoreboard;
        // Copy of the configuration registers.
        logic [15:0] init_v, max_v, min_v, lim, band, up, down;
        logic [21:0] settle_s;
        // Copy of the round state.
        logic [1:0]  mode;
        logic [31:0] entered_ms, stable_ms;
        logic [15:0] setpoint;
        bit          over_hi, over_lo, unstable;
        t_out_item   rounds_due[$];
        int          errors;

        function new();
            {init_v, max_v, min_v, lim, band, up, down} = '0;
            settle_s = '0;
            mode = PS_INITIAL;
            entered_ms = '0;
            stable_ms = '0;
            setpoint = '0;
            {over_hi, over_lo, unstable} = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_INITIAL_VOLTAGE: init_v = data[15:0];
                CFG_MAX_VOLTAGE:     max_v = data[15:0];
                CFG_MIN_VOLTAGE:     min_v = data[15:0];
                CFG_CURRENT_LIMIT:   lim = data[15:0];
                CFG_CURRENT_BAND:    band = data[15:0];
                CFG_STEP_UP:         up = data[15:0];
                CFG_STEP_DOWN:       down = data[15:0];
                CFG_SETTLE_SECONDS:  settle_s = data;
                default: ;
            endcase
        endfunction

        // Notes one accepted input transfer; a closing item queues a result.
        function void take_item(t_in_item it);
            logic [15:0] lo, hi, v;
            logic [1:0]  nxt;
            int          diff;
            t_out_item   r;
            if (it.req_type) begin
                {over_hi, over_lo, unstable} = '0;
            end else begin
                lo = lim - band;
                hi = lim + band;
                diff = int'(it.measured_voltage) - int'(setpoint);
                if (diff > 100 || diff < -100) unstable = 1'b1;
                if (it.measured_current > hi) over_hi = 1'b1;
                if (it.measured_current > lo) over_lo = 1'b1;
                if (!it.last_report) return;
            end

            // The power state moves first, on the setpoint of the old round.
            nxt = mode;
            if (!it.power_on) begin
                nxt = PS_OFF;
            end else if (mode == PS_OFF) begin
                nxt = PS_INITIAL;
            end else if (mode == PS_INITIAL && !it.req_type) begin
                if (unstable) stable_ms = it.now_ms;
                if (it.now_ms - stable_ms >= 32'(settle_s) * 32'd1000 && !unstable)
                    nxt = PS_FULL;
            end
            if (nxt != mode) entered_ms = it.now_ms;
            mode = nxt;

            case (mode)
                PS_INITIAL: v = init_v;
                PS_FULL: begin
                    if (over_hi)
                        v = (down > setpoint) ? 16'd0 : setpoint - down;
                    else if (over_lo)
                        v = setpoint;
                    else if ({1'b0, setpoint} + {1'b0, up} < {1'b0, max_v})
                        v = setpoint + up;
                    else
                        v = setpoint;
                    // A zero setpoint after a step down is never clamped.
                    if (v != 16'd0) begin
                        if (v > max_v) v = max_v;
                        if (v < min_v) v = min_v;
                    end
                end
                default: v = 16'd0;
            endcase
            setpoint = v;
            {over_hi, over_lo, unstable} = '0;

            r.set_voltage = setpoint;
            r.power_state = mode;
            r.state_elapsed_ms = it.now_ms - entered_ms;
            rounds_due.push_back(r);
        endfunction

        function void check_round_result(t_out_item got);
            t_out_item exp_r;
            if (rounds_due.size() == 0) begin
                $display("%0t: unexpected result transfer %h", $time, got);
                errors++;
                return;
            end
            exp_r = rounds_due.pop_front();
            if (got.set_voltage !== exp_r.set_voltage) begin
                $display("%0t: set_voltage expected %h actual %h",
                         $time, exp_r.set_voltage, got.set_voltage);
                errors++;
            end
            if (got.power_state !== exp_r.power_state) begin
                $display("%0t: power_state expected %h actual %h",
                         $time, exp_r.power_state, got.power_state);
                errors++;
            end
            if (got.state_elapsed_ms !== exp_r.state_elapsed_ms) begin
                $display("%0t: state_elapsed_ms expected %h actual %h",
                         $time, exp_r.state_elapsed_ms, got.state_elapsed_ms);
                errors++;
            end
        endfunction

        function int pending();
            return rounds_due.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_item;

    setpoint_scoreboard sb = new();

    // Idling switches for the two sides, and a one-shot request for the
    // receiver to hold off long enough that the block backs up.
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    bit          long_hold = 1'b0;
    int          items_sent = 0;
    logic [31:0] wall_ms = '0;

    psu_current_limit_voltage_sequencer_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: the slowest correct run stays far below this.
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Result side. Stall is raised for a random hold before each result while
    // rx_idle is set, or a long hold on request; inputs change on the falling
    // edge and the transfer is taken on the rising edge with valid and stall low.
    initial begin
        int hold;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (long_hold) begin
                hold = 100;
                long_hold = 1'b0;
            end else begin
                hold = rx_idle ? $urandom_range(0, 5) : 0;
            end
            repeat (hold) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_round_result(o_out_item);
        end
    end

    // Offers one item after a random gap and waits for its transfer. With no
    // gap the valid stays high, so it is never lowered and raised in one step.
    task automatic send_item(input t_in_item it);
        int gap;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_item(it);
        items_sent++;
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Waits until every queued round has come back, then lets the clock run
    // on idle before touching the registers.
    task automatic quiesce();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Writes all eight registers. The unused upper bits of the 16-bit
    // registers carry random junk that the block must ignore.
    task automatic set_config(input logic [15:0] iv, mx, mn, cl, cb, su, sd,
                              input logic [21:0] ss);
        write_reg(CFG_INITIAL_VOLTAGE, {6'($urandom), iv});
        write_reg(CFG_MAX_VOLTAGE, {6'($urandom), mx});
        write_reg(CFG_MIN_VOLTAGE, {6'($urandom), mn});
        write_reg(CFG_CURRENT_LIMIT, {6'($urandom), cl});
        write_reg(CFG_CURRENT_BAND, {6'($urandom), cb});
        write_reg(CFG_STEP_UP, {6'($urandom), su});
        write_reg(CFG_STEP_DOWN, {6'($urandom), sd});
        write_reg(CFG_SETTLE_SECONDS, ss);
    endtask

    task automatic nominal_config();
        logic [15:0] iv;
        iv = 16'($urandom_range(1000, 30000));
        set_config(iv, iv + 16'($urandom_range(0, 20000)), 16'($urandom_range(0, iv)),
                   16'($urandom_range(100, 5000)), 16'($urandom_range(0, 400)),
                   16'($urandom_range(0, 600)), 16'($urandom_range(0, 1500)),
                   22'($urandom_range(0, 2)));
    endtask

    function automatic t_in_item make_item(input bit step, input logic [31:0] now,
                                           input bit pwr, input logic [15:0] volt,
                                           input logic [15:0] curr, input bit last);
        t_in_item it;
        it.req_type = step;
        it.now_ms = now;
        it.power_on = pwr;
        it.measured_voltage = volt;
        it.measured_current = curr;
        it.last_report = last;
        return it;
    endfunction

    // A reading within or just outside the stable window around the setpoint.
    function automatic logic [15:0] near_voltage();
        int v;
        v = int'(sb.setpoint) + int'($urandom_range(0, 202)) - 101;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return 16'(v);
    endfunction

    // Currents cluster below the band and on both of its edges.
    function automatic logic [15:0] pick_current();
        logic [15:0] lo, hi, c;
        lo = sb.lim - sb.band;
        hi = sb.lim + sb.band;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: c = lo - 16'($urandom_range(1, 60));
            4: c = lo;
            5: c = lo + 16'd1;
            6: c = hi;
            7: c = hi + 16'd1;
            default: c = 16'($urandom);
        endcase
        return c;
    endfunction

    function automatic t_in_item good_report(input bit pwr, input bit last);
        logic [15:0] v;
        v = ($urandom_range(0, 99) < 85) ? near_voltage() : 16'($urandom);
        return make_item(1'b0, wall_ms + 32'($urandom_range(0, 9)), pwr, v,
                         pick_current(), last);
    endfunction

    // One round of random stimulus. Most rounds are well formed; the rest
    // are bare step items, rounds cut short by a step item, and raw noise.
    task automatic random_round();
        int  kind, n;
        bit  pwr;
        case ($urandom_range(0, 49))
            0:       wall_ms = $urandom;
            1:       wall_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 3000));
            default: wall_ms = wall_ms + 32'($urandom_range(0, 1500));
        endcase
        kind = $urandom_range(0, 99);
        pwr = ($urandom_range(0, 19) != 0);
        if (kind < 80) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) send_item(good_report(pwr, i == n - 1));
        end else if (kind < 88) begin
            send_item(make_item(1'b1, wall_ms, pwr, 16'($urandom), 16'($urandom),
                                1'($urandom)));
        end else if (kind < 94) begin
            // Pending reports are thrown away by the step item.
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) send_item(good_report(pwr, 1'b0));
            send_item(make_item(1'b1, wall_ms, pwr, 16'($urandom), 16'($urandom),
                                1'($urandom)));
        end else begin
            send_item(make_item(1'b0, $urandom, 1'($urandom), 16'($urandom),
                                16'($urandom), 1'($urandom)));
        end
    endtask

    task automatic random_phase(input int n_items);
        int start;
        start = items_sent;
        while (items_sent - start < n_items) random_round();
        end_burst();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Out of reset every register is zero, so a stable round goes to
        // full power at once and nothing can step the setpoint up.
        send_item(make_item(1'b1, 32'd0, 1'b1, 16'd0, 16'd0, 1'b0));
        send_item(make_item(1'b0, 32'd1, 1'b1, 16'd0, 16'd0, 1'b1));
        send_item(make_item(1'b0, 32'd2, 1'b1, 16'd0, 16'd1, 1'b1));
        end_burst();
        quiesce();

        // Directed rounds on a hand-picked setting: band 900..1100 around a
        // limit of 1000, one second of settling.
        set_config(16'd5000, 16'd12000, 16'd3000, 16'd1000, 16'd100, 16'd250,
                   16'd400, 22'd1);
        send_item(make_item(1'b0, 32'd0, 1'b0, 16'd0, 16'd0, 1'b1));          // off
        send_item(make_item(1'b1, 32'd10, 1'b1, 16'd0, 16'd0, 1'b0));         // to initial
        send_item(make_item(1'b0, 32'd20, 1'b1, 16'd5000, 16'd0, 1'b0));      // no mark
        send_item(make_item(1'b0, 32'd30, 1'b1, 16'd5100, 16'd900, 1'b1));    // edge of window
        send_item(make_item(1'b0, 32'd2000, 1'b1, 16'd4899, 16'd0, 1'b1));    // unstable
        send_item(make_item(1'b0, 32'd2999, 1'b1, 16'd5000, 16'd0, 1'b1));    // not settled
        send_item(make_item(1'b0, 32'd3000, 1'b1, 16'd5000, 16'd0, 1'b1));    // to full
        send_item(make_item(1'b0, 32'd3100, 1'b1, 16'd5250, 16'd1100, 1'b1)); // hold
        send_item(make_item(1'b0, 32'd3200, 1'b1, 16'd5250, 16'd1101, 1'b1)); // step down
        send_item(make_item(1'b0, 32'd3300, 1'b1, 16'd4850, 16'd900, 1'b1));  // step up
        send_item(make_item(1'b0, 32'd3400, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1));
        send_item(make_item(1'b1, 32'd3500, 1'b1, 16'd0, 16'd0, 1'b0));
        send_item(make_item(1'b0, 32'd3600, 1'b1, 16'd0, 16'd2000, 1'b0));
        send_item(make_item(1'b1, 32'd3700, 1'b1, 16'd0, 16'd0, 1'b1));       // discards
        send_item(make_item(1'b0, 32'hFFFF_FFFF, 1'b1, 16'd0, 16'd0, 1'b1));
        send_item(make_item(1'b1, 32'd0, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1));    // off
        send_item(make_item(1'b0, 32'd5, 1'b1, 16'd0, 16'd0, 1'b1));          // back on
        end_burst();

        // Random phases; each one starts from an idle block.
        quiesce();
        nominal_config();
        random_phase(150);

        quiesce();
        set_config('0, '0, '0, '0, '0, '0, '0, '0);
        random_phase(100);

        quiesce();
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 22'h3FFFFF);
        random_phase(100);

        // Band limits that wrap: the lower limit ends up above the upper one.
        quiesce();
        set_config(16'($urandom_range(1000, 40000)), 16'd60000, 16'd100, 16'd50,
                   16'd300, 16'd1000, 16'd200, 22'd0);
        random_phase(150);

        // Step down saturates at zero, and the minimum lies above the maximum.
        quiesce();
        set_config(16'd20000, 16'd15000, 16'd18000, 16'd2000, 16'd50, 16'd3000,
                   16'hFFFF, 22'd1);
        random_phase(150);

        // Fully random setting, no idling on either side.
        quiesce();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom),
                   22'($urandom_range(0, 1)));
        random_phase(150);

        // The receiver holds off while items keep coming, so the block fills.
        quiesce();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        nominal_config();
        long_hold = 1'b1;
        random_phase(150);

        quiesce();
        rx_idle = 1'b0;
        nominal_config();
        random_phase(250);

        quiesce();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
